/* sv/mpf_pkg.sv */
// Package for the multilevel priority FIFO: word types, codes and defaults.
package mpf_pkg;

  // Built configuration defaults.
  localparam int unsigned DefLevels = 8;
  localparam int unsigned DefDepth  = 16;
  localparam int unsigned DefIdBits = 16;

  // Configuration register and port geometry.
  localparam int unsigned CfgW    = 4;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam logic [CfgW-1:0] CfgLevelsReset = 4'd8;

  // Register index, taken from the word address bit of paddr.
  typedef enum logic {
    REG_LEVELS_IN_USE = 1'b0,
    REG_UNUSED        = 1'b1
  } mpf_reg_e;

  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_PEEK    = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_COUNT   = 2'd3
  } mpf_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_PRIO = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } mpf_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OP,
    ST_READ,
    ST_DONE
  } mpf_state_e;

  typedef struct packed {
    mpf_mode_e   mode;
    logic [15:0] task_id;
    logic [3:0]  priority_req;
  } mpf_in_t;

  typedef struct packed {
    logic [15:0] task_out;
    mpf_status_e status;
    logic [4:0]  level_count;
    logic [7:0]  total_count;
    logic        all_empty;
  } mpf_out_t;

endpackage

/* sv/mpf_ram.sv */
// Generic single-port RAM with a registered read port.
module mpf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/multilevel_priority_fifo.sv */
// Multilevel priority FIFO of task ids: one fixed-depth FIFO per priority level.
//
// Each request word is handled alone. After a word is accepted, a sequencer
// walks the active levels one per cycle through a single shared adder: it sums
// the level counts into the total occupancy, finds the first non-empty level
// (priority 1 first) and picks up the count of the requested level. The
// operation state then updates the level's tail (enqueue) or head (remove)
// and count and writes or reads the entry RAM; a peek or remove that finds
// an entry then passes through a read state for the RAM's registered read.
// The number of active levels is min(levels_in_use, LEVELS). A new request
// word is taken in the cycle after the result word is taken, so the block
// works on one request at a time. The entry RAM needs no clearing after
// reset: only entries that an enqueue wrote are ever read. Writing
// levels_in_use is allowed only while idle.
module multilevel_priority_fifo #(
  parameter int unsigned LEVELS  = mpf_pkg::DefLevels,
  parameter int unsigned DEPTH   = mpf_pkg::DefDepth,
  parameter int unsigned ID_BITS = mpf_pkg::DefIdBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mpf_pkg::mpf_in_t            in_word_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mpf_pkg::mpf_out_t           out_word_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpf_pkg::PaddrW-1:0]  paddr,
  input  logic [mpf_pkg::PdataW-1:0]  pwdata,
  output logic [mpf_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  // Stored ids are the request id masked to ID_BITS, never wider than the field.
  localparam int unsigned StoreW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int unsigned LvlW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned TotW   = $clog2(LEVELS * DEPTH + 1);
  localparam int unsigned Words  = LEVELS * DEPTH;
  localparam int unsigned AddrW  = $clog2(Words);

  localparam logic [AddrW-1:0] DepthA   = AddrW'(DEPTH);
  localparam logic [CntW-1:0]  DepthC   = CntW'(DEPTH);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(DEPTH - 1);
  localparam logic [4:0]       LevelsW5 = 5'(LEVELS);

  // ---------------------------------------------------------------------------
  // Configuration register. A write to any other word address is ignored.
  // ---------------------------------------------------------------------------
  logic [mpf_pkg::CfgW-1:0] cfg_q;
  logic                     cfg_hit;

  assign cfg_hit = (paddr[2] == mpf_pkg::REG_LEVELS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mpf_pkg::CfgLevelsReset;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      cfg_q <= pwdata[mpf_pkg::CfgW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg_hit ? mpf_pkg::PdataW'(cfg_q) : '0;

  // The register is clamped to the number of built levels.
  logic [mpf_pkg::CfgW-1:0] n_act;
  logic                     prio_ok;

  assign n_act   = (5'(cfg_q) > LevelsW5) ? mpf_pkg::CfgW'(LEVELS) : cfg_q;
  assign prio_ok = (in_word_i.priority_req != '0) && (in_word_i.priority_req <= n_act);

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  mpf_pkg::mpf_state_e state_q, state_d;

  logic in_fire;
  logic scan_last;
  logic is_pop;

  // Request held for the duration of its processing.
  mpf_pkg::mpf_mode_e       mode_q;
  logic [StoreW-1:0]        tid_q;
  logic [LvlW-1:0]          level_q;
  logic                     prio_ok_q;
  logic [mpf_pkg::CfgW-1:0] n_q;

  // Scan state.
  logic [LvlW-1:0] idx_q;
  logic [TotW-1:0] total_q, total_d;
  logic [TotW-1:0] addend;
  logic            found_q;
  logic [LvlW-1:0] busy_lvl_q;
  logic [CntW-1:0] sel_cnt_q;

  // Result registers.
  logic [StoreW-1:0]    task_q;
  mpf_pkg::mpf_status_e status_q, status_d;
  logic [CntW-1:0]      lcount_q, lcount_d;
  logic [StoreW-1:0]    ram_rdata;

  assign in_fire   = in_valid_i && in_ready_o;
  assign scan_last = (mpf_pkg::CfgW'(idx_q) == (n_q - 1'b1));
  assign is_pop    = (mode_q == mpf_pkg::MODE_PEEK) || (mode_q == mpf_pkg::MODE_REMOVE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mpf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (n_act == '0) ? mpf_pkg::ST_OP : mpf_pkg::ST_SCAN;
        end
      end
      mpf_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = mpf_pkg::ST_OP;
        end
      end
      mpf_pkg::ST_OP: begin
        state_d = (is_pop && found_q) ? mpf_pkg::ST_READ : mpf_pkg::ST_DONE;
      end
      mpf_pkg::ST_READ: begin
        state_d = mpf_pkg::ST_DONE;
      end
      mpf_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = mpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mpf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      mpf_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-level pointers and counts. All reads go through one index: the scan
  // index while scanning, the target level while operating.
  // ---------------------------------------------------------------------------
  logic [PtrW-1:0] head_q [LEVELS];
  logic [PtrW-1:0] tail_q [LEVELS];
  logic [CntW-1:0] cnt_q  [LEVELS];

  logic [LvlW-1:0] lvl_sel;
  logic [LvlW-1:0] arr_idx;
  logic [CntW-1:0] cur_cnt;
  logic [PtrW-1:0] cur_head, cur_tail;
  logic [PtrW-1:0] head_d, tail_d;
  logic [CntW-1:0] cnt_d;
  logic            op_enq, op_rem;

  assign lvl_sel  = is_pop ? busy_lvl_q : level_q;
  assign arr_idx  = (state_q == mpf_pkg::ST_SCAN) ? idx_q : lvl_sel;
  assign cur_cnt  = cnt_q[arr_idx];
  assign cur_head = head_q[arr_idx];
  assign cur_tail = tail_q[arr_idx];

  // Enqueue goes ahead only on a valid priority whose level has room.
  assign op_enq = (state_q == mpf_pkg::ST_OP) && (mode_q == mpf_pkg::MODE_ENQUEUE) &&
                  prio_ok_q && (sel_cnt_q < DepthC);
  assign op_rem = (state_q == mpf_pkg::ST_OP) && (mode_q == mpf_pkg::MODE_REMOVE) && found_q;

  assign head_d = (cur_head == PtrLast) ? '0 : cur_head + 1'b1;
  assign tail_d = (cur_tail == PtrLast) ? '0 : cur_tail + 1'b1;
  assign cnt_d  = op_enq ? cur_cnt + 1'b1 : cur_cnt - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(LEVELS); i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (op_enq) begin
        tail_q[arr_idx] <= tail_d;
      end
      if (op_rem) begin
        head_q[arr_idx] <= head_d;
      end
      if (op_enq || op_rem) begin
        cnt_q[arr_idx] <= cnt_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared adder: sums counts during the scan, then applies the +1 or -1 of
  // the operation so that the reported total is the one after this request.
  // ---------------------------------------------------------------------------
  always_comb begin
    addend = '0;
    if (state_q == mpf_pkg::ST_SCAN) begin
      addend = TotW'(cur_cnt);
    end else if (op_enq) begin
      addend = TotW'(1);
    end else if (op_rem) begin
      addend = '1;
    end
  end

  assign total_d = total_q + addend;

  // Status and level count of the operation.
  always_comb begin
    status_d = mpf_pkg::STATUS_OK;
    lcount_d = '0;
    case (mode_q)
      mpf_pkg::MODE_ENQUEUE: begin
        if (!prio_ok_q) begin
          status_d = mpf_pkg::STATUS_BAD_PRIO;
        end else if (sel_cnt_q >= DepthC) begin
          status_d = mpf_pkg::STATUS_FULL;
        end
      end
      mpf_pkg::MODE_PEEK, mpf_pkg::MODE_REMOVE: begin
        if (!found_q) begin
          status_d = mpf_pkg::STATUS_EMPTY;
        end
      end
      mpf_pkg::MODE_COUNT: begin
        if (!prio_ok_q) begin
          status_d = mpf_pkg::STATUS_BAD_PRIO;
        end else begin
          lcount_d = sel_cnt_q;
        end
      end
      default: begin
        status_d = mpf_pkg::STATUS_OK;
      end
    endcase
  end

  // Scan bookkeeping and result capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      total_q    <= '0;
      found_q    <= 1'b0;
      busy_lvl_q <= '0;
      sel_cnt_q  <= '0;
    end else if (in_fire) begin
      idx_q      <= '0;
      total_q    <= '0;
      found_q    <= 1'b0;
      busy_lvl_q <= '0;
      sel_cnt_q  <= '0;
    end else if (state_q == mpf_pkg::ST_SCAN) begin
      total_q <= total_d;
      if (!found_q && (cur_cnt != '0)) begin
        found_q    <= 1'b1;
        busy_lvl_q <= idx_q;
      end
      if (idx_q == level_q) begin
        sel_cnt_q <= cur_cnt;
      end
      if (!scan_last) begin
        idx_q <= idx_q + 1'b1;
      end
    end else if (state_q == mpf_pkg::ST_OP) begin
      total_q <= total_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= in_word_i.mode;
      tid_q     <= in_word_i.task_id[StoreW-1:0];
      level_q   <= LvlW'(in_word_i.priority_req - 4'd1);
      prio_ok_q <= prio_ok;
      n_q       <= n_act;
    end
    if (state_q == mpf_pkg::ST_OP) begin
      task_q   <= '0;
      status_q <= status_d;
      lcount_q <= lcount_d;
    end
    if (state_q == mpf_pkg::ST_READ) begin
      task_q <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry RAM: level l occupies words l*DEPTH to l*DEPTH + DEPTH - 1.
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0]  ram_addr;
  logic [PtrW-1:0]   ram_ptr;

  assign ram_ptr  = (mode_q == mpf_pkg::MODE_ENQUEUE) ? cur_tail : cur_head;
  assign ram_addr = AddrW'(lvl_sel) * DepthA + AddrW'(ram_ptr);

  mpf_ram #(
    .WIDTH (StoreW),
    .DEPTH (Words)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (op_enq),
    .addr_i  (ram_addr),
    .wdata_i (tid_q),
    .rdata_o (ram_rdata)
  );

  // Result word.
  assign out_word_o.task_out    = 16'(task_q);
  assign out_word_o.status      = status_q;
  assign out_word_o.level_count = 5'(lcount_q);
  assign out_word_o.total_count = 8'(total_q);
  assign out_word_o.all_empty   = (total_q == '0);

`ifndef SYNTH
  // Only one request word is in flight: never ready while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while a result word is pending");

  // No level ever holds more than DEPTH entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpf_pkg::ST_SCAN) |-> (cur_cnt <= DepthC))
    else $error("level count above depth");

  // A successful enqueue raises the running total by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_enq |=> (total_q == $past(total_q) + TotW'(1)))
    else $error("total not advanced on enqueue");

  // An empty-store result carries a zero task id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == mpf_pkg::STATUS_EMPTY)) |->
      (out_word_o.task_out == '0))
    else $error("nonzero task id on empty result");

  // A result is offered only after the operation cycle has run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == mpf_pkg::ST_OP ||
                            $past(state_q) == mpf_pkg::ST_READ))
    else $error("result offered without an operation");
`endif

endmodule
